>>> rtl/lzwd_pkg.sv
package lzwd_pkg;

  localparam int DICT_SIZE = 4096;
  localparam int MAX_LEN   = 64;
  localparam int ALPHA     = 256;

  localparam int BYTE_W = 8;
  localparam int CODE_W = $clog2(DICT_SIZE);
  localparam int NF_W   = CODE_W + 1;
  localparam int LEN_W  = $clog2(MAX_LEN + 1);
  localparam int IDX_W  = $clog2(MAX_LEN);
  localparam int TOT_W  = LEN_W + 1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_WALK,
    ST_HEAD,
    ST_BODY,
    ST_TAIL,
    ST_ERR
  } state_t;

  typedef enum logic [1:0] {
    SEL_HEAD,
    SEL_BODY,
    SEL_TAIL,
    SEL_ERR
  } emit_sel_t;

  typedef struct packed {
    logic      load;
    logic      walk;
    logic      emit;
    emit_sel_t sel;
    logic      last;
    logic      commit;
  } cmd_t;

  typedef struct packed {
    logic bad;
    logic kwk;
    logic chain_end;
    logic too_long;
    logic total_long;
    logic body_none;
    logic body_one;
    logic out_free;
  } sts_t;

endpackage

>>> rtl/lzw_decoder_unit.sv
// LZW decoder, 8-bit alphabet, 12-bit codes, 4096-entry dictionary.
// Input channel: in_valid / in_stall carry one code per beat (in_code).
// Output channel: out_valid / out_stall carry one byte per beat; out_last_byte
// marks the final byte of a code's string, out_error marks a single error
// beat (byte 0, last set) for an out-of-range code or a string over 64 bytes.
// Per code: the code is accepted, the prefix chain is walked (one dictionary
// read per cycle, the dictionary's single registered read port sets this),
// then the string's bytes go out at one per cycle while the output does not
// stall, plus one more byte for the KwKwK case. An out-of-range code goes
// straight to the error beat; an over-long string is caught in the walk.
// One code is in flight at a time: in_stall is high from acceptance until the
// last byte of the code has been loaded into the output register.
// The output register decouples the sides: the next code may be taken while
// the last byte still waits. A stall on the output freezes the byte walk; no
// beat is lost or repeated.
// Reset (rst_n low, synchronous) empties the dictionary (next free slot 256),
// forgets the previous code and drops out_valid. Dictionary contents are not
// cleared; only entries already written are ever read.
module lzw_decoder_unit (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [lzwd_pkg::CODE_W-1:0] in_code,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [lzwd_pkg::BYTE_W-1:0] out_byte,
  output logic                        out_last_byte,
  output logic                        out_error
);
  import lzwd_pkg::*;

  cmd_t cmd;   // controller -> datapath
  sts_t sts;   // datapath -> controller

  // sequencer: accept, chain walk, emit head / body / tail, error beat
  lzwd_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  // dictionary, reversal stack, code checks and output register
  lzwd_dpath u_dpath (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_code       (in_code),
    .cmd           (cmd),
    .sts           (sts),
    .out_stall     (out_stall),
    .out_valid     (out_valid),
    .out_byte      (out_byte),
    .out_last_byte (out_last_byte),
    .out_error     (out_error)
  );

endmodule

>>> rtl/lzwd_ctrl.sv
module lzwd_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  input  lzwd_pkg::sts_t sts,
  output lzwd_pkg::cmd_t cmd
);
  import lzwd_pkg::*;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    cmd.sel   = SEL_HEAD;
    in_stall  = (state_r != ST_IDLE);
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = sts.bad ? ST_ERR : ST_WALK;
        end
      end
      ST_WALK: begin
        cmd.walk = 1'b1;
        priority if (sts.too_long) begin
          state_nxt = ST_ERR;
        end else if (sts.chain_end) begin
          state_nxt = sts.total_long ? ST_ERR : ST_HEAD;
        end else begin
          state_nxt = ST_WALK;
        end
      end
      ST_HEAD: begin
        if (sts.out_free) begin
          cmd.emit = 1'b1;
          cmd.sel  = SEL_HEAD;
          cmd.last = sts.body_none && !sts.kwk;
          priority if (!sts.body_none) begin
            state_nxt = ST_BODY;
          end else if (sts.kwk) begin
            state_nxt = ST_TAIL;
          end else begin
            cmd.commit = 1'b1;
            state_nxt  = ST_IDLE;
          end
        end
      end
      ST_BODY: begin
        if (sts.out_free) begin
          cmd.emit = 1'b1;
          cmd.sel  = SEL_BODY;
          cmd.last = sts.body_one && !sts.kwk;
          if (sts.body_one) begin
            if (sts.kwk) begin
              state_nxt = ST_TAIL;
            end else begin
              cmd.commit = 1'b1;
              state_nxt  = ST_IDLE;
            end
          end
        end
      end
      ST_TAIL: begin
        if (sts.out_free) begin
          cmd.emit   = 1'b1;
          cmd.sel    = SEL_TAIL;
          cmd.last   = 1'b1;
          cmd.commit = 1'b1;
          state_nxt  = ST_IDLE;
        end
      end
      ST_ERR: begin
        if (sts.out_free) begin
          cmd.emit  = 1'b1;
          cmd.sel   = SEL_ERR;
          cmd.last  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

>>> rtl/lzwd_dpath.sv
module lzwd_dpath (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic [lzwd_pkg::CODE_W-1:0]   in_code,
  input  lzwd_pkg::cmd_t                cmd,
  output lzwd_pkg::sts_t                sts,
  input  logic                          out_stall,
  output logic                          out_valid,
  output logic [lzwd_pkg::BYTE_W-1:0]   out_byte,
  output logic                          out_last_byte,
  output logic                          out_error
);
  import lzwd_pkg::*;

  // dictionary and reversal stack
  logic [CODE_W-1:0] prefix_mem [DICT_SIZE];
  logic [BYTE_W-1:0] suffix_mem [DICT_SIZE];
  logic [BYTE_W-1:0] stk_mem    [MAX_LEN];

  logic [CODE_W-1:0] pre_rd_r;
  logic [BYTE_W-1:0] suf_rd_r;
  logic [BYTE_W-1:0] stk_rd_r;

  logic [NF_W-1:0]   next_free_r;
  logic [CODE_W-1:0] prev_code_r;
  logic              prev_valid_r;

  logic [CODE_W-1:0] code_r;
  logic [CODE_W-1:0] c_r;
  logic              kwk_r;
  logic [LEN_W-1:0]  n_r;
  logic [BYTE_W-1:0] first_r;
  logic [IDX_W-1:0]  pop_idx_r, pop_idx_nxt;
  logic [LEN_W-1:0]  body_cnt_r;

  logic              out_valid_r;
  logic [BYTE_W-1:0] out_byte_r;
  logic              out_last_r;
  logic              out_err_r;

  logic [NF_W-1:0]   code_ext;
  logic              nf_full;
  logic              kwk_in;
  logic              bad_in;
  logic [CODE_W-1:0] start_code;
  logic [CODE_W-1:0] rd_addr;
  logic              chain_end;
  logic              too_long;
  logic [BYTE_W-1:0] push_byte;
  logic [TOT_W-1:0]  total;
  logic              commit_wr;
  logic              out_free;

  assign code_ext   = {1'b0, in_code};
  assign nf_full    = (next_free_r >= NF_W'(DICT_SIZE));
  assign kwk_in     = prev_valid_r && (code_ext == next_free_r) && !nf_full;
  assign bad_in     = prev_valid_r ? ((code_ext > next_free_r) ||
                                      ((code_ext == next_free_r) && nf_full))
                                   : (in_code >= CODE_W'(ALPHA));
  assign start_code = kwk_in ? prev_code_r : in_code;
  assign rd_addr    = cmd.load ? start_code : pre_rd_r;

  assign chain_end  = (c_r < CODE_W'(ALPHA));
  assign too_long   = (n_r >= LEN_W'(MAX_LEN));
  assign push_byte  = chain_end ? c_r[BYTE_W-1:0] : suf_rd_r;
  assign total      = TOT_W'(n_r) + TOT_W'(1) + TOT_W'(kwk_r);
  assign commit_wr  = cmd.commit && prev_valid_r && !nf_full;
  assign out_free   = !out_valid_r || !out_stall;

  always_comb begin
    pop_idx_nxt = pop_idx_r;
    if (cmd.walk && !too_long && chain_end) begin
      pop_idx_nxt = n_r[IDX_W-1:0] - IDX_W'(1);
    end else if (cmd.emit && (cmd.sel == SEL_BODY)) begin
      pop_idx_nxt = pop_idx_r - IDX_W'(1);
    end
  end

  assign sts.bad        = bad_in;
  assign sts.kwk        = kwk_r;
  assign sts.chain_end  = chain_end;
  assign sts.too_long   = too_long;
  assign sts.total_long = (total > TOT_W'(MAX_LEN));
  assign sts.body_none  = (body_cnt_r == '0);
  assign sts.body_one   = (body_cnt_r == LEN_W'(1));
  assign sts.out_free   = out_free;

  // dictionary: one write port at commit, one registered read port
  always_ff @(posedge clk) begin
    if (commit_wr) begin
      prefix_mem[next_free_r[CODE_W-1:0]] <= prev_code_r;
      suffix_mem[next_free_r[CODE_W-1:0]] <= first_r;
    end
    pre_rd_r <= prefix_mem[rd_addr];
    suf_rd_r <= suffix_mem[rd_addr];
  end

  // stack: the top entry is never read back, it lives in first_r
  always_ff @(posedge clk) begin
    if (cmd.walk && !too_long) begin
      stk_mem[n_r[IDX_W-1:0]] <= push_byte;
    end
    stk_rd_r <= stk_mem[pop_idx_nxt];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      next_free_r  <= NF_W'(ALPHA);
      prev_code_r  <= '0;
      prev_valid_r <= 1'b0;
    end else if (cmd.commit) begin
      if (commit_wr) begin
        next_free_r <= next_free_r + NF_W'(1);
      end
      prev_code_r  <= code_r;
      prev_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    pop_idx_r <= pop_idx_nxt;
    if (cmd.load) begin
      code_r <= in_code;
      c_r    <= start_code;
      kwk_r  <= kwk_in;
      n_r    <= '0;
    end else if (cmd.walk && !too_long) begin
      n_r <= n_r + LEN_W'(1);
      if (chain_end) begin
        first_r    <= c_r[BYTE_W-1:0];
        body_cnt_r <= n_r;
      end else begin
        c_r <= pre_rd_r;
      end
    end else if (cmd.emit && (cmd.sel == SEL_BODY)) begin
      body_cnt_r <= body_cnt_r - LEN_W'(1);
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_last_r <= cmd.last;
      unique case (cmd.sel)
        SEL_HEAD: begin
          out_byte_r <= first_r;
          out_err_r  <= 1'b0;
        end
        SEL_BODY: begin
          out_byte_r <= stk_rd_r;
          out_err_r  <= 1'b0;
        end
        SEL_TAIL: begin
          out_byte_r <= first_r;
          out_err_r  <= 1'b0;
        end
        SEL_ERR: begin
          out_byte_r <= '0;
          out_err_r  <= 1'b1;
        end
        default: begin
          out_byte_r <= '0;
          out_err_r  <= 1'b1;
        end
      endcase
    end
  end

  assign out_valid     = out_valid_r;
  assign out_byte      = out_byte_r;
  assign out_last_byte = out_last_r;
  assign out_error     = out_err_r;

endmodule
